// File: sv/sps_pkg.sv
// Shared types and constants for the selection sampler.
`default_nettype none
package sps_pkg;

    localparam int WORD_W    = 64;
    localparam int CNT_W     = 21;
    localparam int VALUE_W   = 31;
    localparam int SLOT_W    = 20;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W    = $clog2(WORD_W);

    localparam int DEF_MAX_POPULATION = 1048576;

    localparam int ROT_A   = 24;
    localparam int SHIFT_B = 16;
    localparam int ROT_B   = 37;

    localparam logic [WORD_W-1:0] SEED0_RST = WORD_W'(1);
    localparam logic [WORD_W-1:0] SEED1_RST = '0;
    localparam logic [CNT_W-1:0]  SAMP_RST  = '0;
    localparam logic [CNT_W-1:0]  POP_RST   = CNT_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED0 = 2'd0,
        CFG_SEED1 = 2'd1,
        CFG_SAMP  = 2'd2,
        CFG_POP   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

endpackage
`default_nettype wire

// File: sv/sps_serial_mod.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`default_nettype none
module sps_serial_mod (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [sps_pkg::WORD_W-1:0] i_dividend,
    input  wire logic [sps_pkg::CNT_W-1:0]  i_divisor,
    output logic                           o_done,
    output logic [sps_pkg::CNT_W-1:0]       o_rem
);
    import sps_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [WORD_W-1:0] r_shift;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [CNT_W:0]    c_trial;
    logic [CNT_W:0]    c_diff;
    logic [CNT_W-1:0]  n_rem;

    always_comb begin
        c_trial = {r_rem, r_shift[WORD_W-1]};
        c_diff  = c_trial - {1'b0, r_div};
        if (c_trial >= {1'b0, r_div}) begin
            n_rem = c_diff[CNT_W-1:0];
        end else begin
            n_rem = c_trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt   <= STEP_W'(WORD_W - 1);
            r_shift <= i_dividend;
            r_rem   <= '0;
            r_div   <= i_divisor;
        end else if (r_busy) begin
            r_cnt   <= r_cnt - STEP_W'(1);
            r_shift <= {r_shift[WORD_W-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// File: sv/selection_sampler_prng_top.sv
// Top level of the selection sampler with its xoroshiro128+ generator.
//
// Channels: item input (i_item_valid / o_item_ready), selection output
// (o_sel_valid / i_sel_ready) and a configuration write channel
// (i_cfg_valid / o_cfg_ready, always ready) carrying a register index and
// 64-bit data: 0 seed word 0, 1 seed word 1, 2 sample size, 3 population.
// A seed write loads that generator word at once.
// An item that needs a draw steps the generator at the transfer edge, then
// passes through the bit-serial remainder unit (one bit of the 64-bit draw
// per cycle), then its done flag, then a compare-and-emit step.
// An item that needs no draw (sample already complete) produces no result.
// One item is in flight at a time, so an item that draws must finish its
// compare-and-emit step before the next item is taken.
// The result sits in an output register; the next item is taken while it
// waits. If the receiver stalls and a new result is ready, the block holds
// it in the compare stage until the output register frees.
// Reset loads the generator with 1 and 0, sample size 0, population 1,
// and clears both counters and the output valid flag.
`default_nettype none
module selection_sampler_prng_top #(
    parameter int MAX_POPULATION = sps_pkg::DEF_MAX_POPULATION
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [sps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [sps_pkg::WORD_W-1:0]    i_cfg_data,
    input  wire logic                          i_item_valid,
    output logic                               o_item_ready,
    input  wire logic [sps_pkg::VALUE_W-1:0]   i_item_value,
    output logic                               o_sel_valid,
    input  wire logic                          i_sel_ready,
    output logic [sps_pkg::VALUE_W-1:0]        o_selected_value,
    output logic [sps_pkg::SLOT_W-1:0]         o_sample_slot,
    output logic                               o_last_of_sample
);
    import sps_pkg::*;

    localparam logic [31:0] MaxPop = 32'(MAX_POPULATION);

    t_state r_state, n_state;

    logic [WORD_W-1:0]  r_gen0, r_gen1;
    logic [CNT_W-1:0]   r_samp, r_pop;
    logic [CNT_W-1:0]   r_seen, r_taken;
    logic [VALUE_W-1:0] r_value;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic [SLOT_W-1:0]  r_out_slot;
    logic               r_out_last;

    logic [31:0]        c_pop32;
    logic [CNT_W-1:0]   c_pop, c_samp;
    logic [CNT_W-1:0]   c_seen0, c_taken0;
    logic [CNT_W-1:0]   c_seen1, c_taken1;
    logic [CNT_W-1:0]   c_need;
    logic               c_accept, c_draw, c_hit, c_out_free, c_emit;
    logic [WORD_W-1:0]  c_sum, c_b, c_gen0, c_gen1;
    logic               c_div_start, c_div_done;
    logic [CNT_W-1:0]   c_rem;

    // effective sizes
    always_comb begin
        c_pop32 = {{(32 - CNT_W){1'b0}}, r_pop};
        if (c_pop32 == '0) begin
            c_pop32 = 32'd1;
        end
        if (c_pop32 > MaxPop) begin
            c_pop32 = MaxPop;
        end
        c_pop  = c_pop32[CNT_W-1:0];
        c_samp = (r_samp < c_pop) ? r_samp : c_pop;
    end

    // generator step
    always_comb begin
        c_sum  = r_gen0 + r_gen1;
        c_b    = r_gen0 ^ r_gen1;
        c_gen0 = {r_gen0[WORD_W-1-ROT_A:0], r_gen0[WORD_W-1:WORD_W-ROT_A]}
                 ^ c_b ^ (c_b << SHIFT_B);
        c_gen1 = {c_b[WORD_W-1-ROT_B:0], c_b[WORD_W-1:WORD_W-ROT_B]};
    end

    always_comb begin
        c_accept   = i_item_valid && o_item_ready;
        c_seen0    = (r_seen >= c_pop) ? '0 : r_seen;
        c_taken0   = (r_seen >= c_pop) ? '0 : r_taken;
        c_draw     = c_taken0 < c_samp;
        c_need     = c_samp - r_taken;
        c_hit      = {{(32 - CNT_W){1'b0}}, c_rem} < {{(32 - CNT_W){1'b0}}, c_need};
        c_out_free = !r_out_valid || i_sel_ready;
        c_seen1    = r_seen + CNT_W'(1);
        c_taken1   = r_taken + (c_hit ? CNT_W'(1) : '0);
    end

    always_comb begin
        n_state     = r_state;
        o_item_ready = 1'b0;
        c_div_start = 1'b0;
        c_emit      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_item_ready = 1'b1;
                if (c_accept && c_draw) begin
                    c_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (c_div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!c_hit || c_out_free) begin
                    c_emit  = c_hit;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration, generator and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen0  <= SEED0_RST;
            r_gen1  <= SEED1_RST;
            r_samp  <= SAMP_RST;
            r_pop   <= POP_RST;
            r_seen  <= '0;
            r_taken <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SEED0: r_gen0 <= i_cfg_data;
                    CFG_SEED1: r_gen1 <= i_cfg_data;
                    CFG_SAMP:  r_samp <= i_cfg_data[CNT_W-1:0];
                    CFG_POP:   r_pop  <= i_cfg_data[CNT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (c_accept) begin
                if (c_draw) begin
                    r_gen0  <= c_gen0;
                    r_gen1  <= c_gen1;
                    r_seen  <= c_seen0;
                    r_taken <= c_taken0;
                end else if (c_seen0 + CNT_W'(1) >= c_pop) begin
                    r_seen  <= '0;
                    r_taken <= '0;
                end else begin
                    r_seen  <= c_seen0 + CNT_W'(1);
                    r_taken <= c_taken0;
                end
            end
            if (r_state == S_EMIT && n_state == S_IDLE) begin
                if (c_seen1 >= c_pop) begin
                    r_seen  <= '0;
                    r_taken <= '0;
                end else begin
                    r_seen  <= c_seen1;
                    r_taken <= c_taken1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_value <= i_item_value;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_sel_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_emit) begin
            r_out_value <= r_value;
            r_out_slot  <= r_taken[SLOT_W-1:0];
            r_out_last  <= (c_taken1 == c_samp);
        end
    end

    sps_serial_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (c_div_start),
        .i_dividend (c_sum),
        .i_divisor  (c_pop - c_seen0),
        .o_done     (c_div_done),
        .o_rem      (c_rem)
    );

    assign o_cfg_ready      = 1'b1;
    assign o_sel_valid      = r_out_valid;
    assign o_selected_value = r_out_value;
    assign o_sample_slot    = r_out_slot;
    assign o_last_of_sample = r_out_last;

endmodule
`default_nettype wire
